// ===== hdl/urf_pkg.sv =====
// ----------------------------------------------------------------------------
// urf_pkg
// Shared types and constants for the unmatched run finder.
// ----------------------------------------------------------------------------
package urf_pkg;

    localparam int unsigned POSITION_BITS_DEF = 32;
    localparam int unsigned FIELD_BITS        = 32;
    localparam logic [FIELD_BITS-1:0] MIN_LENGTH_RESET = 32'd1;

    // One scanned position
    typedef struct packed {
        logic matched;
        logic seq_boundary;
        logic last;
    } t_in_item;

    // One reported unmarked run
    typedef struct packed {
        logic [FIELD_BITS-1:0] region_start;
        logic [FIELD_BITS-1:0] region_seq;
        logic [FIELD_BITS-1:0] region_rel_start;
        logic [FIELD_BITS-1:0] region_length;
    } t_out_item;

endpackage

// ===== hdl/urf_step.sv =====
// ----------------------------------------------------------------------------
// urf_step
// Next-state and result logic for one scanned position.
// ----------------------------------------------------------------------------
module urf_step
    import urf_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
    input  t_in_item                 i_item,
    input  logic [FIELD_BITS-1:0]    i_min_length,
    input  logic [POSITION_BITS-1:0] i_pos,
    input  logic                     i_run_open,
    input  logic [POSITION_BITS-1:0] i_run_begin,
    input  logic [POSITION_BITS-1:0] i_seq_index,
    input  logic [POSITION_BITS-1:0] i_seq_begin,
    output logic [POSITION_BITS-1:0] o_pos,
    output logic                     o_run_open,
    output logic [POSITION_BITS-1:0] o_run_begin,
    output logic [POSITION_BITS-1:0] o_seq_index,
    output logic [POSITION_BITS-1:0] o_seq_begin,
    output logic                     o_res_valid,
    output t_out_item                o_res
);

    // Compare width covers both the position width and the register width
    localparam int unsigned CW = (POSITION_BITS > FIELD_BITS) ? POSITION_BITS : FIELD_BITS;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    logic [POSITION_BITS-1:0] pos_inc;
    logic [POSITION_BITS-1:0] seq_index_inc;
    logic                     run_open_a;
    logic [POSITION_BITS-1:0] run_begin_a;
    logic [POSITION_BITS-1:0] seq_index_a;
    logic [POSITION_BITS-1:0] seq_begin_a;
    logic                     close_mark;
    logic                     flush;
    logic [POSITION_BITS-1:0] run_len;
    logic [POSITION_BITS-1:0] rep_seq_index;
    logic [POSITION_BITS-1:0] rep_seq_begin;
    logic [CW-1:0]            len_w;
    logic [CW-1:0]            min_w;
    logic [CW-1:0]            begin_w;
    logic [CW-1:0]            rel_w;
    logic [CW-1:0]            seq_w;

    assign pos_inc       = (i_pos == POS_MAX) ? i_pos : i_pos + 1'b1;
    assign seq_index_inc = (i_seq_index == POS_MAX) ? i_seq_index : i_seq_index + 1'b1;

    // Mark check first, then sequence bookkeeping
    assign close_mark  = i_item.matched && i_run_open;
    assign run_open_a  = !i_item.matched;
    assign run_begin_a = (!i_item.matched && !i_run_open) ? i_pos : i_run_begin;
    assign seq_index_a = i_item.seq_boundary ? seq_index_inc : i_seq_index;
    assign seq_begin_a = i_item.seq_boundary ? pos_inc : i_seq_begin;

    // Flush at end of scan includes the last position and sees updated sequence values
    assign flush         = i_item.last && !i_item.matched;
    assign run_len       = flush ? (pos_inc - run_begin_a) : (i_pos - i_run_begin);
    assign rep_seq_index = flush ? seq_index_a : i_seq_index;
    assign rep_seq_begin = flush ? seq_begin_a : i_seq_begin;

    assign len_w   = CW'(run_len);
    assign min_w   = CW'(i_min_length);
    assign begin_w = CW'(run_begin_a);
    assign seq_w   = CW'(rep_seq_index);
    assign rel_w   = begin_w - CW'(rep_seq_begin);

    assign o_res_valid = (close_mark || flush) && !(len_w < min_w);

    always_comb begin
        o_res.region_start     = begin_w[FIELD_BITS-1:0];
        o_res.region_seq       = seq_w[FIELD_BITS-1:0];
        o_res.region_rel_start = rel_w[FIELD_BITS-1:0];
        o_res.region_length    = len_w[FIELD_BITS-1:0];
    end

    always_comb begin
        if (i_item.last) begin
            o_pos       = '0;
            o_run_open  = 1'b0;
            o_run_begin = '0;
            o_seq_index = '0;
            o_seq_begin = '0;
        end else begin
            o_pos       = pos_inc;
            o_run_open  = run_open_a;
            o_run_begin = run_begin_a;
            o_seq_index = seq_index_a;
            o_seq_begin = seq_begin_a;
        end
    end

endmodule

// ===== hdl/unmatched_run_finder.sv =====
// ----------------------------------------------------------------------------
// unmatched_run_finder
// Reports runs of unmarked positions that reach a configured minimum length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / i_in_data / o_in_stall) takes one position per
//   transaction. Output channel (o_out_valid / o_out_data / i_out_stall) gives
//   at most one region per position. Config channel (i_cfg_valid / i_cfg_data /
//   o_cfg_ready) writes min_length; ready is always high, write only when idle.
//   A region is registered into the output register, or into the skid register
//   when a stalled receiver holds the output register. Throughput: one position
//   per cycle while o_in_stall is low, set by the state update in urf_step.
//   A two-entry output stage (output register plus skid register) lets input
//   carry on while the receiver stalls until a second region is waiting;
//   o_in_stall rises only when both entries hold a region.
//   Reset clears the scan state, empties the output stage and sets min_length
//   to 1. A position with last set ends the scan and returns scan state to
//   its reset value; min_length is kept.
// ----------------------------------------------------------------------------
module unmatched_run_finder
    import urf_pkg::*;
#(
    parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  t_in_item              i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output t_out_item             o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic [FIELD_BITS-1:0] i_cfg_data,
    output logic                  o_cfg_ready
);

    logic [FIELD_BITS-1:0]    r_min_length;
    logic [POSITION_BITS-1:0] r_pos;
    logic                     r_run_open;
    logic [POSITION_BITS-1:0] r_run_begin;
    logic [POSITION_BITS-1:0] r_seq_index;
    logic [POSITION_BITS-1:0] r_seq_begin;
    logic                     r_out_valid;
    t_out_item                r_out;
    logic                     r_skid_valid;
    t_out_item                r_skid;

    logic [POSITION_BITS-1:0] n_pos;
    logic                     n_run_open;
    logic [POSITION_BITS-1:0] n_run_begin;
    logic [POSITION_BITS-1:0] n_seq_index;
    logic [POSITION_BITS-1:0] n_seq_begin;
    logic                     res_valid;
    t_out_item                res;
    logic                     in_accept;
    logic                     new_valid;
    logic                     out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign new_valid = in_accept && res_valid;
    assign out_free  = !r_out_valid || !i_out_stall;

    urf_step #(
        .POSITION_BITS(POSITION_BITS)
    ) u_step (
        .i_item      (i_in_data),
        .i_min_length(r_min_length),
        .i_pos       (r_pos),
        .i_run_open  (r_run_open),
        .i_run_begin (r_run_begin),
        .i_seq_index (r_seq_index),
        .i_seq_begin (r_seq_begin),
        .o_pos       (n_pos),
        .o_run_open  (n_run_open),
        .o_run_begin (n_run_begin),
        .o_seq_index (n_seq_index),
        .o_seq_begin (n_seq_begin),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_length <= MIN_LENGTH_RESET;
            r_pos        <= '0;
            r_run_open   <= 1'b0;
            r_run_begin  <= '0;
            r_seq_index  <= '0;
            r_seq_begin  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_min_length <= i_cfg_data;
            end
            if (in_accept) begin
                r_pos       <= n_pos;
                r_run_open  <= n_run_open;
                r_run_begin <= n_run_begin;
                r_seq_index <= n_seq_index;
                r_seq_begin <= n_seq_begin;
            end
        end
    end

    // Output stage: skid entry drains first to keep order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= new_valid;
            end else begin
                r_out_valid  <= new_valid;
            end
        end else if (new_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
                if (new_valid) begin
                    r_skid <= res;
                end
            end else if (new_valid) begin
                r_out <= res;
            end
        end else if (new_valid) begin
            r_skid <= res;
        end
    end

endmodule

// ===== hdl/urf_checker.sv =====
// ----------------------------------------------------------------------------
// urf_checker
// Port-level checks for the unmatched run finder, bound to the top level.
// ----------------------------------------------------------------------------
module urf_checker
    import urf_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input t_out_item o_out_data,
    input logic      i_out_stall
);

    // A held region must not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output region changed while stalled");

    // A new region needs a position accepted the cycle before
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall))
        else $error("region appeared without an accepted position");

    // Input stalls only when the output stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    // Input stall only follows a receiver stall
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_out_stall))
        else $error("input stall without receiver stall");

endmodule

bind unmatched_run_finder urf_checker u_urf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .o_out_valid(o_out_valid),
    .o_out_data (o_out_data),
    .i_out_stall(i_out_stall)
);

// ===== dv/tb_unmatched_run_finder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unmatched_run_finder
// Self-checking bench for the unmatched run finder. A directed set of short
// scans covers run closure by a marked position, flush on the last position,
// runs that straddle a sequence separator and the minimum length extremes.
// Random scans follow under several minimum lengths, with random gaps on the
// input and random stalls on the output. Expected regions come from a
// behavioural model of the scan state, updated on every input transaction.
// ----------------------------------------------------------------------------
module tb_unmatched_run_finder
    import urf_pkg::*;
();

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 7;
    localparam int unsigned WDOG_LIMIT    = 1000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam logic [FIELD_BITS-1:0] MIN_LEN_NONE = '1;

    typedef logic [POSITION_BITS_DEF-1:0] t_pos;
    typedef logic [FIELD_BITS-1:0]        t_field;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_in_valid;
    t_in_item        i_in_data;
    logic            o_in_stall;
    logic            o_out_valid;
    t_out_item       o_out_data;
    logic            i_out_stall = 1'b0;
    logic            i_cfg_valid;
    t_field          i_cfg_data;
    logic            o_cfg_ready;

    // scan state model
    t_field          min_len_cfg;
    t_pos            scan_pos;
    logic            run_is_open;
    t_pos            run_start_pos;
    t_pos            seq_num;
    t_pos            seq_start_pos;

    t_out_item       expected_regions[$];
    int unsigned     fault_count = 0;
    int unsigned     idle_cycles = 0;
    int unsigned     rx_hold = 0;
    bit              calm = 1'b0;

    unmatched_run_finder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------
    function automatic t_pos sat_next(input t_pos v);
        return (v == '1) ? v : t_pos'(v + 1'b1);
    endfunction

    function automatic void clear_scan();
        scan_pos      = '0;
        run_is_open   = 1'b0;
        run_start_pos = '0;
        seq_num       = '0;
        seq_start_pos = '0;
    endfunction

    // Fills in the region for the open run; true if it meets the minimum
    function automatic bit make_region(input logic [63:0] len, output t_out_item r);
        logic [63:0] rel;
        rel                = 64'(run_start_pos) - 64'(seq_start_pos);
        r.region_start     = t_field'(run_start_pos);
        r.region_seq       = t_field'(seq_num);
        r.region_rel_start = rel[FIELD_BITS-1:0];
        r.region_length    = len[FIELD_BITS-1:0];
        return len >= 64'(min_len_cfg);
    endfunction

    function automatic bit predict_region(input t_in_item item, output t_out_item r);
        t_pos pos;
        bit   hit;
        pos = scan_pos;
        hit = 1'b0;
        r   = '0;
        if (item.matched) begin
            if (run_is_open) begin
                hit         = make_region(64'(pos) - 64'(run_start_pos), r);
                run_is_open = 1'b0;
            end
        end else if (!run_is_open) begin
            run_is_open   = 1'b1;
            run_start_pos = pos;
        end
        // separator update comes after the mark check
        if (item.seq_boundary) begin
            seq_num       = sat_next(seq_num);
            seq_start_pos = sat_next(pos);
        end
        if (item.last) begin
            // flush includes this position and sees the updated sequence
            if (run_is_open) begin
                hit = make_region(64'(sat_next(pos)) - 64'(run_start_pos), r);
            end
            clear_scan();
        end else begin
            scan_pos = sat_next(pos);
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------------
    // Shared helpers
    // ------------------------------------------------------------------------
    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic t_in_item pos_item(input logic m, input logic b, input logic l);
        t_in_item it;
        it.matched      = m;
        it.seq_boundary = b;
        it.last         = l;
        return it;
    endfunction

    task automatic log_fault(input string msg);
        if (fault_count < MAX_REPORTS) begin
            $display("%0t: %s", $realtime, msg);
        end
        fault_count++;
    endtask

    task automatic check_field(input string name, input t_field want, input t_field got);
        if (want !== got) begin
            log_fault($sformatf("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got));
        end
    endtask

    task automatic send_item(input t_in_item item);
        int unsigned gap;
        t_out_item   r;
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        if (predict_region(item, r)) begin
            expected_regions.push_back(r);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_regions.size() != 0) @(posedge i_clk);
        // let anything still in flight come out
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_length(input t_field v);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        min_len_cfg = v;
    endtask

    task automatic send_random_scan();
        int unsigned len;
        int unsigned mark_pct;
        int unsigned bound_pct;
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 30);
        bound_pct = $urandom_range(0, 15);
        calm      = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 3))
            0: mark_pct = 5;
            1: mark_pct = 30;
            2: mark_pct = 50;
            default: mark_pct = 85;
        endcase
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                // noise: may end the scan early
                send_item(pos_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                   $urandom_range(0, 5) == 0));
            end else begin
                send_item(pos_item($urandom_range(0, 99) < mark_pct,
                                   $urandom_range(0, 99) < bound_pct, k == len - 1));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side: random stalls and checking
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        int unsigned hold;
        t_out_item   want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_hold     <= 0;
        end else if (o_out_valid && !i_out_stall) begin
            if (expected_regions.size() == 0) begin
                log_fault($sformatf("unexpected region: start 0x%08h length 0x%08h",
                                    o_out_data.region_start, o_out_data.region_length));
            end else begin
                want = expected_regions.pop_front();
                check_field("region_start", want.region_start, o_out_data.region_start);
                check_field("region_seq", want.region_seq, o_out_data.region_seq);
                check_field("region_rel_start", want.region_rel_start,
                            o_out_data.region_rel_start);
                check_field("region_length", want.region_length, o_out_data.region_length);
            end
            hold = draw_gap();
            rx_hold     <= hold;
            i_out_stall <= (hold != 0);
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            if (rx_hold == 1) begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // counts cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Default minimum: closure by a mark, run over a separator, flush at last
    task automatic test_directed_scans();
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b1, 1'b0));  // separator inside the run
        send_item(pos_item(1'b1, 1'b0, 1'b0));  // closes; rel start wraps
        send_item(pos_item(1'b1, 1'b1, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b1));  // flush includes this position
        send_item(pos_item(1'b0, 1'b1, 1'b1));  // one-position scan, updated seq
        send_item(pos_item(1'b1, 1'b0, 1'b1));
        send_item(pos_item(1'b1, 1'b1, 1'b1));
    endtask

    task automatic test_min_length_extremes();
        write_min_length(MIN_LEN_NONE);
        repeat (4) send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b1, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b1));
        write_min_length('0);
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b1, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b1));
        write_min_length(t_field'(2));
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b1, 1'b0, 1'b0));  // too short
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b0, 1'b0, 1'b0));
        send_item(pos_item(1'b1, 1'b0, 1'b1));
    endtask

    task automatic test_random_scans(input t_field min_len, input int unsigned n_items);
        int unsigned sent;
        write_min_length(min_len);
        sent = 0;
        while (sent < n_items) begin
            send_random_scan();
            sent = sent + 1;
        end
    endtask

    // Sender holds off mid-stream until the output side has caught up
    task automatic test_drain_pause();
        write_min_length(t_field'(1));
        repeat (4) send_random_scan();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_regions.size() != 0);
        repeat (4) send_random_scan();
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        min_len_cfg = MIN_LENGTH_RESET;
        clear_scan();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_scans();
        test_min_length_extremes();
        // counts are in scans; a scan averages about 22 positions
        test_random_scans(t_field'(1), 12);
        test_random_scans('0, 6);
        test_random_scans(t_field'(4), 8);
        test_random_scans(t_field'(2), 6);
        test_drain_pause();
        wait_idle();

        if (fault_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
